// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
// Each macro samples on the rising edge of clock and is held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// A condition that, when seen, must be followed by another at the next sampled edge.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/srbr_pkg.sv
package srbr_pkg;

   localparam int RX_DEPTH  = 256;
   localparam int TX_DEPTH  = 256;
   localparam int FRAME_MAX = 32;
   localparam int READ_CAP  = 64;

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);

   // Width of the byte count of one read or one frame.
   localparam int TAKE_W = 7;
   localparam int BLEN_W = 9;

   // Widths for comparing a ring count against a take limit or a burst end.
   localparam int RX_MW = (RX_CW > TAKE_W) ? RX_CW : TAKE_W;
   localparam int TX_MW = (TX_CW > TAKE_W) ? TX_CW : TAKE_W;
   localparam int RX_SW = ((RX_CW > BLEN_W) ? RX_CW : BLEN_W) + 1;
   localparam int TX_SW = ((TX_CW > BLEN_W) ? TX_CW : BLEN_W) + 1;

   typedef enum logic [2:0] {
      OP_LINE_BYTE  = 3'd0,
      OP_HOST_WRITE = 3'd1,
      OP_HOST_READ  = 3'd2,
      OP_TX_DONE    = 3'd3,
      OP_FLUSH      = 3'd4,
      OP_INIT       = 3'd5,
      OP_DEINIT     = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS  = 2'd0,
      KIND_RX_BYTE = 2'd1,
      KIND_TX_BYTE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOINIT  = 3'd1,
      ST_INVALID = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic exec;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic streams;
      logic out_free;
      logic last_byte;
   } dp_sts_type;

endpackage

// File: rtl/core/srbr_req_if.sv
interface srbr_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [7:0] data_byte;
   logic       first_of_burst;
   logic [8:0] burst_length;
   logic [6:0] max_length;

   modport source (output valid, operation, data_byte, first_of_burst, burst_length,
                   max_length, input ready);
   modport sink (input valid, operation, data_byte, first_of_burst, burst_length,
                 max_length, output ready);
endinterface

interface srbr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte_res;
   logic [2:0] status;
   logic       last;
   logic [6:0] read_count;
   logic       rx_available;

   modport source (output valid, kind, data_byte_res, status, last, read_count,
                   rx_available, input ready);
   modport sink (input valid, kind, data_byte_res, status, last, read_count,
                 rx_available, output ready);
endinterface

// File: rtl/core/serial_rx_tx_ring_buffers.sv
// Receive and transmit byte rings for a buffered serial link. Every command
// (line byte, host write byte, host read, tx done, flush tick, init, deinit)
// is one beat on the request channel. Commands that produce a single status
// beat do not hold the block: a new request is taken in the cycle after as
// long as the response register is free or being drained. A host read or a
// flush that moves data produces one response beat per byte. Each ring sits
// in a memory with a registered read port, so every byte is first fetched
// (FETCH) and then loaded into the response register (EMIT), which waits
// until that register is free or being drained. A read moves up to 64 bytes,
// and a flush up to 32 bytes. No new request is taken while a read or flush
// is streaming. The last beat of each command has last set; rx_available
// reflects the state after the whole command. Ring contents are not cleared at
// reset; init empties both rings by resetting their pointers.
module serial_rx_tx_ring_buffers
   import srbr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   srbr_req_if.sink  req_if,
   srbr_rsp_if.source rsp_if
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;

   srbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   srbr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .operation      (req_if.operation),
      .data_byte      (req_if.data_byte),
      .first_of_burst (req_if.first_of_burst),
      .burst_length   (req_if.burst_length),
      .max_length     (req_if.max_length),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .kind           (rsp_if.kind),
      .data_byte_res  (rsp_if.data_byte_res),
      .status         (rsp_if.status),
      .last           (rsp_if.last),
      .read_count     (rsp_if.read_count),
      .rx_available   (rsp_if.rx_available)
   );

endmodule

// File: rtl/core/srbr_ctrl.sv
module srbr_ctrl
   import srbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_sts_type   sts,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EMIT
   } state_type;

   state_type state_ff;

   always_comb begin
      req_ready = (state_ff == S_IDLE) && sts.out_free;
      cmd.exec  = req_valid && req_ready;
      cmd.emit  = (state_ff == S_EMIT) && sts.out_free;
   end

   // FETCH lets the memory present the byte at the read pointer before EMIT loads it.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.exec && sts.streams) state_ff <= S_FETCH;
            end
            S_FETCH: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (cmd.emit) state_ff <= sts.last_byte ? S_IDLE : S_FETCH;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/srbr_dp.sv
module srbr_dp
   import srbr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [2:0]   operation,
   input  logic [7:0]   data_byte,
   input  logic         first_of_burst,
   input  logic [8:0]   burst_length,
   input  logic [6:0]   max_length,
   input  ctrl_cmd_type cmd,
   output dp_sts_type   sts,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic [1:0]   kind,
   output logic [7:0]   data_byte_res,
   output logic [2:0]   status,
   output logic         last,
   output logic [6:0]   read_count,
   output logic         rx_available
);

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];
   logic [7:0] rx_rd_ff, tx_rd_ff;

   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [RX_CW-1:0] rx_count_ff, rx_count_in;
   logic [TX_CW-1:0] tx_count_ff, tx_count_in;
   logic tx_busy_ff, tx_busy_in, init_ff, init_in;
   logic rx_ref_ff, rx_ref_in, tx_ref_ff, tx_ref_in;
   logic [TAKE_W-1:0] remain_ff, remain_in, take_ff, take_in;
   logic stream_rx_ff, stream_rx_in;

   logic             rsp_valid_ff;
   kind_type         kind_ff;
   logic [7:0]       data_ff;
   status_type       status_ff;
   logic             last_ff;
   logic [TAKE_W-1:0] rcount_ff;
   logic             avail_ff;

   op_type            op;
   status_type        st;
   logic              avail_in;
   logic              rx_wr, tx_wr;
   logic [TAKE_W-1:0] want, rx_take, tx_take;
   logic [RX_MW-1:0]  rx_min;
   logic [TX_MW-1:0]  tx_min;
   logic [RX_SW-1:0]  rx_sum;
   logic [TX_SW-1:0]  tx_sum;
   logic              zero_len, rx_ref_now, tx_ref_now, rx_push_ok, tx_push_ok;
   logic              rx_stream, tx_stream;
   logic [RX_AW-1:0]  rx_head_nx, rx_tail_nx;
   logic [TX_AW-1:0]  tx_head_nx, tx_tail_nx;

   always_comb begin
      op   = op_type'(operation);
      want = (max_length > TAKE_W'(READ_CAP)) ? TAKE_W'(READ_CAP) : max_length;

      rx_min  = (RX_MW'(rx_count_ff) < RX_MW'(want)) ? RX_MW'(rx_count_ff) : RX_MW'(want);
      rx_take = TAKE_W'(rx_min);
      tx_min  = (TX_MW'(tx_count_ff) < TX_MW'(FRAME_MAX)) ? TX_MW'(tx_count_ff)
                                                          : TX_MW'(FRAME_MAX);
      tx_take = TAKE_W'(tx_min);

      // A first byte decides for the whole burst whether it fits.
      zero_len   = (burst_length == '0);
      rx_sum     = RX_SW'(rx_count_ff) + RX_SW'(burst_length);
      tx_sum     = TX_SW'(tx_count_ff) + TX_SW'(burst_length);
      rx_ref_now = first_of_burst ? (zero_len || rx_sum > RX_SW'(RX_DEPTH)) : rx_ref_ff;
      tx_ref_now = first_of_burst ? (zero_len || tx_sum > TX_SW'(TX_DEPTH)) : tx_ref_ff;
      rx_push_ok = !rx_ref_now && (rx_count_ff < RX_CW'(RX_DEPTH));
      tx_push_ok = !tx_ref_now && (tx_count_ff < TX_CW'(TX_DEPTH));

      rx_stream = init_ff && (op == OP_HOST_READ) && (rx_count_ff != '0) && (want != '0);
      tx_stream = init_ff && (op == OP_FLUSH) && !tx_busy_ff && (tx_count_ff != '0);

      rx_head_nx = (rx_head_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_ff + 1'b1;
      rx_tail_nx = (rx_tail_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_ff + 1'b1;
      tx_head_nx = (tx_head_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_ff + 1'b1;
      tx_tail_nx = (tx_tail_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_ff + 1'b1;
   end

   always_comb begin
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      rx_count_in  = rx_count_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      tx_count_in  = tx_count_ff;
      tx_busy_in   = tx_busy_ff;
      init_in      = init_ff;
      rx_ref_in    = rx_ref_ff;
      tx_ref_in    = tx_ref_ff;
      remain_in    = remain_ff;
      take_in      = take_ff;
      stream_rx_in = stream_rx_ff;
      st           = ST_OK;
      rx_wr        = 1'b0;
      tx_wr        = 1'b0;

      if (cmd.exec) begin
         unique case (op)
            OP_LINE_BYTE: begin
               if (!init_ff) begin
                  st = ST_NOINIT;
               end else begin
                  rx_ref_in = rx_ref_now;
                  if (first_of_burst && zero_len) st = ST_INVALID;
                  else if (!rx_push_ok) st = ST_FULL;
                  if (rx_push_ok) begin
                     rx_wr       = 1'b1;
                     rx_head_in  = rx_head_nx;
                     rx_count_in = rx_count_ff + 1'b1;
                  end
               end
            end
            OP_HOST_WRITE: begin
               if (!init_ff) begin
                  st = ST_NOINIT;
               end else begin
                  tx_ref_in = tx_ref_now;
                  if (first_of_burst && zero_len) st = ST_INVALID;
                  else if (!tx_push_ok) st = ST_FULL;
                  if (tx_push_ok) begin
                     tx_wr       = 1'b1;
                     tx_head_in  = tx_head_nx;
                     tx_count_in = tx_count_ff + 1'b1;
                  end
               end
            end
            OP_HOST_READ: begin
               if (!init_ff) begin
                  st = ST_NOINIT;
               end else if (rx_count_ff == '0) begin
                  st = ST_EMPTY;
               end else if (rx_stream) begin
                  rx_count_in  = rx_count_ff - RX_CW'(rx_take);
                  remain_in    = rx_take;
                  take_in      = rx_take;
                  stream_rx_in = 1'b1;
               end
            end
            OP_TX_DONE: begin
               if (!init_ff) st = ST_NOINIT;
               else tx_busy_in = 1'b0;
            end
            OP_FLUSH: begin
               if (!init_ff) begin
                  st = ST_NOINIT;
               end else if (tx_stream) begin
                  tx_count_in  = tx_count_ff - TX_CW'(tx_take);
                  tx_busy_in   = 1'b1;
                  remain_in    = tx_take;
                  take_in      = tx_take;
                  stream_rx_in = 1'b0;
               end
            end
            OP_INIT: begin
               rx_head_in  = '0;
               rx_tail_in  = '0;
               rx_count_in = '0;
               tx_head_in  = '0;
               tx_tail_in  = '0;
               tx_count_in = '0;
               tx_busy_in  = 1'b0;
               rx_ref_in   = 1'b0;
               tx_ref_in   = 1'b0;
               init_in     = 1'b1;
            end
            OP_DEINIT: begin
               init_in = 1'b0;
            end
            default: st = ST_INVALID;
         endcase
      end

      if (cmd.emit) begin
         remain_in = remain_ff - 1'b1;
         if (stream_rx_ff) rx_tail_in = rx_tail_nx;
         else tx_tail_in = tx_tail_nx;
      end

      avail_in = init_in && (rx_count_in != '0);
   end

   always_comb begin
      sts.streams   = rx_stream || tx_stream;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
      sts.last_byte = (remain_ff == TAKE_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_count_ff  <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_count_ff  <= '0;
         tx_busy_ff   <= 1'b0;
         init_ff      <= 1'b0;
         rx_ref_ff    <= 1'b0;
         tx_ref_ff    <= 1'b0;
         remain_ff    <= '0;
         take_ff      <= '0;
         stream_rx_ff <= 1'b0;
      end else begin
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_count_ff  <= rx_count_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_count_ff  <= tx_count_in;
         tx_busy_ff   <= tx_busy_in;
         init_ff      <= init_in;
         rx_ref_ff    <= rx_ref_in;
         tx_ref_ff    <= tx_ref_in;
         remain_ff    <= remain_in;
         take_ff      <= take_in;
         stream_rx_ff <= stream_rx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_wr) rx_mem[rx_head_ff] <= data_byte;
      rx_rd_ff <= rx_mem[rx_tail_ff];
   end

   always_ff @(posedge clock) begin
      if (tx_wr) tx_mem[tx_head_ff] <= data_byte;
      tx_rd_ff <= tx_mem[tx_tail_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.exec && !sts.streams) || cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The availability flag is taken when the item enters, so every byte of a
   // read or frame carries the state as it stands after the whole item.
   always_ff @(posedge clock) begin
      if (cmd.exec) avail_ff <= avail_in;
      if (cmd.exec && !sts.streams) begin
         kind_ff   <= KIND_STATUS;
         data_ff   <= '0;
         status_ff <= st;
         last_ff   <= 1'b1;
         rcount_ff <= '0;
      end else if (cmd.emit) begin
         kind_ff   <= stream_rx_ff ? KIND_RX_BYTE : KIND_TX_BYTE;
         data_ff   <= stream_rx_ff ? rx_rd_ff : tx_rd_ff;
         status_ff <= ST_OK;
         last_ff   <= sts.last_byte;
         rcount_ff <= (sts.last_byte && stream_rx_ff) ? take_ff : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign kind          = kind_ff;
   assign data_byte_res = data_ff;
   assign status        = status_ff;
   assign last          = last_ff;
   assign read_count    = rcount_ff;
   assign rx_available  = avail_ff;

endmodule

// File: rtl/core/srbr_checker.sv
`include "assert_macros.svh"

module srbr_checker
   import srbr_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data,
   input logic [2:0] rsp_status,
   input logic       rsp_last,
   input logic [6:0] rsp_read_count
);

   // A beat that waits must stay valid, and its byte, kind and last flag must not change under the consumer.
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_kind) && $stable(rsp_last))

   // Status-only beats always close their command and carry no byte.
   `ASSERT_ALWAYS(a_status_beat, !(rsp_valid && rsp_kind == KIND_STATUS) || (rsp_last && rsp_data == 8'd0))

   // An error code only travels on a status-only beat.
   `ASSERT_ALWAYS(a_error_kind, !(rsp_valid && rsp_status != ST_OK) || rsp_kind == KIND_STATUS)

   // A byte count appears only on the closing beat of a host read.
   `ASSERT_ALWAYS(a_read_count, !(rsp_valid && rsp_read_count != 7'd0) || (rsp_last && rsp_kind == KIND_RX_BYTE))

endmodule

bind serial_rx_tx_ring_buffers srbr_checker u_srbr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_kind       (rsp_if.kind),
   .rsp_data       (rsp_if.data_byte_res),
   .rsp_status     (rsp_if.status),
   .rsp_last       (rsp_if.last),
   .rsp_read_count (rsp_if.read_count)
);
